// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the synchronous reset is released.
`define PCDP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PCDP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/pcdp_pkg.sv
// ----------------------------------------------------------------------------
// Packed-code dot product package
// Widths, payload types and lane control shared by the block's files.
// ----------------------------------------------------------------------------
package pcdp_pkg;

  localparam int unsigned CHUNK_ELEMS = 8;
  localparam int unsigned QUERY_W     = 8 * CHUNK_ELEMS;
  localparam int unsigned LOW_W       = 7 * CHUNK_ELEMS;
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned CFG_W       = 4;
  localparam int unsigned LW_W        = 3;
  localparam int unsigned PROD_W      = 16;
  localparam int unsigned SUM_W       = PROD_W + $clog2(CHUNK_ELEMS);
  localparam int unsigned DOT_W       = 32;

  localparam logic [CFG_W-1:0] LEVEL_BITS_RESET = 4'd4;
  localparam logic [CFG_W-1:0] LEVEL_BITS_MIN   = 4'd2;
  localparam logic [CFG_W-1:0] LEVEL_BITS_MAX   = 4'd8;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef prod_t [CHUNK_ELEMS-1:0]  prod_vec_t;
  typedef logic signed [SUM_W-1:0]  chunk_sum_t;
  typedef logic signed [DOT_W-1:0]  dot_t;

  // Control that the top level hands to every lane.
  typedef struct packed {
    logic            load;
    logic [LW_W-1:0] low_width;
  } lane_ctl_t;

endpackage

// File: sv/pcdp_if.sv
// ----------------------------------------------------------------------------
// Packed-code dot product channels
// Valid/ready channels for incoming chunk words and outgoing results.
// ----------------------------------------------------------------------------
interface pcdp_in_if;
  import pcdp_pkg::*;

  logic               valid;
  logic               ready;
  logic [QUERY_W-1:0] query_bytes;
  logic [7:0]         sign_bits;
  logic [LOW_W-1:0]   low_bits;
  logic [COUNT_W-1:0] valid_count;
  logic               last_chunk;

  modport source (output valid, query_bytes, sign_bits, low_bits, valid_count, last_chunk,
                  input ready);
  modport sink   (input valid, query_bytes, sign_bits, low_bits, valid_count, last_chunk,
                  output ready);
endinterface

interface pcdp_out_if;
  import pcdp_pkg::*;

  logic valid;
  logic ready;
  dot_t dot_product;

  modport source (output valid, dot_product, input ready);
  modport sink   (input valid, dot_product, output ready);
endinterface

// File: sv/pcdp_lane.sv
// ----------------------------------------------------------------------------
// Packed-code dot product lane
// Decodes one element's level and registers its product with the query byte.
// ----------------------------------------------------------------------------
module pcdp_lane #(
  parameter int unsigned LANE_IDX = 0
) (
  input  logic                    clk,
  input  pcdp_pkg::lane_ctl_t     ctl,
  input  logic [7:0]              query_byte,
  input  logic                    sign_bit,
  input  logic [pcdp_pkg::LOW_W-1:0] low_bits,
  input  logic                    lane_on,
  output pcdp_pkg::prod_t         product_r
);
  import pcdp_pkg::*;

  logic [5:0]        shift_amt;
  logic [LOW_W-1:0]  low_shifted;
  logic [6:0]        code_mask;
  logic [6:0]        code;
  logic [7:0]        half;
  logic signed [8:0] level_wide;
  logic signed [7:0] level;
  logic signed [7:0] query;
  prod_t             product_nxt;

  // Element LANE_IDX starts at bit LANE_IDX * (B-1) of the packed low codes.
  assign shift_amt   = 6'(LANE_IDX * ctl.low_width);
  assign low_shifted = low_bits >> shift_amt;
  assign code_mask   = 7'((8'd1 << ctl.low_width) - 8'd1);
  assign code        = low_shifted[6:0] & code_mask;
  assign half        = 8'd1 << ctl.low_width;

  // A set sign bit keeps the low code as is; a clear one moves it below zero.
  assign level_wide  = sign_bit ? $signed({2'b00, code})
                                : $signed({2'b00, code}) - $signed({1'b0, half});
  assign level       = level_wide[7:0];
  assign query       = $signed(query_byte);
  assign product_nxt = PROD_W'(query) * PROD_W'(level);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      product_r <= lane_on ? product_nxt : '0;
    end
  end

endmodule

// File: sv/pcdp_merge.sv
// ----------------------------------------------------------------------------
// Packed-code dot product merge
// Adds the lane products of one chunk into a registered chunk sum.
// ----------------------------------------------------------------------------
module pcdp_merge (
  input  logic                  clk,
  input  logic                  load,
  input  pcdp_pkg::prod_vec_t   products,
  output pcdp_pkg::chunk_sum_t  chunk_sum_r
);
  import pcdp_pkg::*;

  chunk_sum_t chunk_sum_nxt;

  always_comb begin
    chunk_sum_nxt = '0;
    for (int i = 0; i < CHUNK_ELEMS; i++) begin
      chunk_sum_nxt = chunk_sum_nxt + SUM_W'(products[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chunk_sum_r <= chunk_sum_nxt;
    end
  end

endmodule

// File: sv/packed_code_dot_product.sv
// ----------------------------------------------------------------------------
// Packed-code dot product
// Streams chunks of multi-bit codes against an int8 query and emits the
// saturated dot product of each vector.
// ----------------------------------------------------------------------------
// The block takes one chunk word per clock cycle and never stalls its source
// while the result side is ready. The word that closes the vector passes
// through the lane product registers and the chunk sum register before its
// result is registered on the result port. The eight decode-and-multiply lanes
// register their products at the accepting edge. The adder that merges them
// then registers the chunk sum. Next, the add-and-saturate step on the running
// sum loads the output register; that step is also the loop through the
// running sum register that carries one chunk into the next. The result sits
// in an output register, so words keep flowing in while a finished result
// waits; when the result side stalls, the three stages fill and only then
// does the input side see ready drop.
// The code width B is set through the configuration port and must only change
// while no vector is in flight; out-of-range values are pinned to 2 or 8.
// ----------------------------------------------------------------------------
module packed_code_dot_product (
  input  logic                     clk,
  input  logic                     rst_n,
  pcdp_in_if.sink                  in_ch,
  pcdp_out_if.source               out_ch,
  input  logic                     cfg_we,
  input  logic [pcdp_pkg::CFG_W-1:0] cfg_wdata
);
  import pcdp_pkg::*;

  // Configuration: bits per level, B.
  logic [CFG_W-1:0] level_bits_r;
  logic [LW_W-1:0]  low_width;

  // Pipeline occupancy.
  logic s1_valid_r, s1_valid_nxt, s1_last_r;
  logic s2_valid_r, s2_valid_nxt, s2_last_r;
  logic out_free, s2_take, s2_open, s1_take, s1_open, in_accept;

  // Datapath.
  lane_ctl_t          lane_ctl;
  prod_vec_t          products;
  chunk_sum_t         chunk_sum;
  dot_t               running_sum_r, running_sum_nxt;
  logic signed [DOT_W:0] acc_wide;
  dot_t               acc_sat;
  logic               out_valid_r, out_valid_nxt;
  dot_t               out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_bits_r <= LEVEL_BITS_RESET;
    end else if (cfg_we) begin
      level_bits_r <= cfg_wdata;
    end
  end

  // The low code width is B-1, with B pinned to its meaningful range.
  always_comb begin
    if (level_bits_r < LEVEL_BITS_MIN) begin
      low_width = LW_W'(LEVEL_BITS_MIN - 4'd1);
    end else if (level_bits_r > LEVEL_BITS_MAX) begin
      low_width = LW_W'(LEVEL_BITS_MAX - 4'd1);
    end else begin
      low_width = LW_W'(level_bits_r - 4'd1);
    end
  end

  // Flow control. Each stage advances when the stage after it is empty or
  // moving on. A non-final chunk leaves the sum stage without a result, so
  // only the closing chunk needs the output register to be free.
  assign out_free  = !out_valid_r || out_ch.ready;
  assign s2_take   = s2_valid_r && (!s2_last_r || out_free);
  assign s2_open   = !s2_valid_r || s2_take;
  assign s1_take   = s1_valid_r && s2_open;
  assign s1_open   = !s1_valid_r || s1_take;
  assign in_accept = in_ch.valid && s1_open;

  assign in_ch.ready = s1_open;

  // Stage one: the lanes decode and multiply in parallel.
  assign lane_ctl.load      = in_accept;
  assign lane_ctl.low_width = low_width;

  for (genvar k = 0; k < CHUNK_ELEMS; k++) begin : g_lane
    pcdp_lane #(
      .LANE_IDX (k)
    ) u_lane (
      .clk        (clk),
      .ctl        (lane_ctl),
      .query_byte (in_ch.query_bytes[8*k +: 8]),
      .sign_bit   (in_ch.sign_bits[k]),
      .low_bits   (in_ch.low_bits),
      .lane_on    (in_ch.valid_count > COUNT_W'(k)),
      .product_r  (products[k])
    );
  end

  // Stage two: the merge adder sums the lane products.
  pcdp_merge u_merge (
    .clk         (clk),
    .load        (s1_take),
    .products    (products),
    .chunk_sum_r (chunk_sum)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_take) begin
      s1_valid_nxt = 1'b0;
    end
    s2_valid_nxt = s2_valid_r;
    if (s1_take) begin
      s2_valid_nxt = 1'b1;
    end else if (s2_take) begin
      s2_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_last_r <= in_ch.last_chunk;
    end
    if (s1_take) begin
      s2_last_r <= s1_last_r;
    end
  end

  // Stage three: add the chunk sum to the running sum and saturate. The sum
  // is cleared once the closing chunk's total has gone to the output register.
  assign acc_wide = (DOT_W+1)'(running_sum_r) + (DOT_W+1)'(chunk_sum);

  always_comb begin
    if (acc_wide[DOT_W] != acc_wide[DOT_W-1]) begin
      acc_sat = acc_wide[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}} : {1'b0, {(DOT_W-1){1'b1}}};
    end else begin
      acc_sat = acc_wide[DOT_W-1:0];
    end
  end

  always_comb begin
    running_sum_nxt = running_sum_r;
    if (s2_take) begin
      running_sum_nxt = s2_last_r ? '0 : acc_sat;
    end
    out_valid_nxt = out_valid_r;
    if (s2_take && s2_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_sum_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      running_sum_r <= running_sum_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take && s2_last_r) begin
      out_data_r <= acc_sat;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.dot_product = out_data_r;

endmodule

// File: sv/pcdp_checker.sv
// ----------------------------------------------------------------------------
// Packed-code dot product checker
// Port-level assertions on the result channel and on input throughput.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcdp_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input pcdp_pkg::dot_t        out_dot_product
);
  import pcdp_pkg::*;

  logic stalled;

  assign stalled = out_valid && !out_ready;

  // A result that is not taken stays offered.
  `PCDP_ASSERT(a_out_hold, clk, rst_n, stalled |=> out_valid, "result dropped")

  // A stalled result keeps its value.
  `PCDP_ASSERT(a_out_stable, clk, rst_n, stalled |=> $stable(out_dot_product), "result changed")

  // With the result side ready, the pipeline always has room for a new word.
  `PCDP_ASSERT(a_full_rate, clk, rst_n, out_ready |-> in_ready, "input stalled")

  // Reset leaves no result pending.
  `PCDP_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind packed_code_dot_product pcdp_checker u_pcdp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_dot_product (out_ch.dot_product)
);
